// ----- design/assert_macros.svh -----
// assertion macros included by hue_rotate_color_generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- design/hrcg_pkg.sv -----
// ----------------------------------------------------------------------------
// hrcg_pkg
// types and constants of the hue rotate colour generator
// ----------------------------------------------------------------------------
package hrcg_pkg;
	localparam int unsigned CH_BITS = 8;
	localparam int unsigned IN_BITS = 32;
	localparam int unsigned CFG_BITS = 32;

	typedef logic [CH_BITS-1:0] chan_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
	} rgb_t;
endpackage

// ----- design/hrcg_if.sv -----
// ----------------------------------------------------------------------------
// hrcg_in_if / hrcg_out_if
// valid/ready channels of the colour generator
// ----------------------------------------------------------------------------
interface hrcg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] iteration_count;
	modport source (output valid, output iteration_count, input ready);
	modport sink (input valid, input iteration_count, output ready);
endinterface

interface hrcg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		output ready);
endinterface

// ----- design/hrcg_divider.sv -----
// ----------------------------------------------------------------------------
// hrcg_divider
// unsigned restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module hrcg_divider #(
	parameter int unsigned NUM_BITS = 24,
	parameter int unsigned DEN_BITS = 11,
	parameter int unsigned TAG_BITS = 8
) (
	input  logic                clk,
	input  logic                en,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	input  logic [TAG_BITS-1:0] tag_in,
	output logic [NUM_BITS-1:0] quo,
	output logic [TAG_BITS-1:0] tag_out
);
	logic [DEN_BITS:0]   rem_s [NUM_BITS+1];
	logic [NUM_BITS-1:0] nq_s  [NUM_BITS+1];
	logic [DEN_BITS-1:0] den_s [NUM_BITS+1];
	logic [TAG_BITS-1:0] tag_s [NUM_BITS+1];

	assign rem_s[0] = '0;
	assign nq_s[0]  = num;
	assign den_s[0] = den;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < NUM_BITS; i++) begin : g_st
		logic [DEN_BITS+1:0] sh;
		logic [DEN_BITS+1:0] df;
		assign sh = {rem_s[i], nq_s[i][NUM_BITS-1]};
		assign df = sh - {2'b00, den_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!df[DEN_BITS+1]) begin
					rem_s[i+1] <= df[DEN_BITS:0];
				end else begin
					rem_s[i+1] <= sh[DEN_BITS:0];
				end
				nq_s[i+1]  <= {nq_s[i][NUM_BITS-2:0], ~df[DEN_BITS+1]};
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign quo     = nq_s[NUM_BITS];
	assign tag_out = tag_s[NUM_BITS];
endmodule

// ----- design/hue_rotate_color_generator.sv -----
// ----------------------------------------------------------------------------
// hue_rotate_color_generator
// maps an iteration count to one rgb colour by rotating the hue of the
// programmed base colour
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  in_ch     sink  iteration_count
//  out_ch    src   red_out, green_out, blue_out
//  cfg       in    cfg_we, cfg_wdata (base colour word)
//
//  one beat per cycle while the output is not stalled; a beat passes
//  stages 1 and 2, the bit-per-stage hue and saturation dividers, then
//  stages a to d. the whole pipeline advances only when the output register
//  can move, so a stall holds every stage in place
//  arst_n clears valid bits and the base colour
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hue_rotate_color_generator
	import hrcg_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	hrcg_in_if.sink             in_ch,
	hrcg_out_if.source          out_ch
);
	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned NB  = F + 11;          // dividend bits
	localparam int unsigned LAT = NB;
	localparam int unsigned CB  = (COUNT_BITS < 32) ? COUNT_BITS : 32;

	logic [CFG_BITS-1:0] base_q;
	logic                adv;
	logic [LAT+5:0]      vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	assign adv         = !vld_s[LAT+5] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT+4:0], in_ch.valid};
		end
	end

	// stage 1: residue mod 255 folded by bytes, colour min/max
	logic [7:0]  r, g, b, mx, mn;
	logic [9:0]  fold;
	logic [9:0]  fold_s1;
	logic [7:0]  r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [63:0] cnt_ext;
	logic [2:0]  jj_s2;

	assign r = base_q[31:24];
	assign g = base_q[23:16];
	assign b = base_q[15:8];
	assign mx = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
	assign mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
	assign cnt_ext = {{(64-CB){1'b0}}, in_ch.iteration_count[CB-1:0]};
	assign fold = 10'(cnt_ext[7:0]) + 10'(cnt_ext[15:8])
		+ 10'(cnt_ext[23:16]) + 10'(cnt_ext[31:24]);

	always_ff @(posedge clk) begin
		if (adv) begin
			fold_s1 <= fold;
			r_s1 <= r; g_s1 <= g; b_s1 <= b; mx_s1 <= mx; mn_s1 <= mn;
		end
	end

	// stage 2: finish residue, build dividends
	logic [9:0]    f2;
	logic [7:0]    res;
	logic [6:0]    rh;
	logic [3:0]    s3a;
	logic [2:0]    s3b;
	logic [1:0]    m3;
	logic [7:0]    c1;
	logic signed [11:0] num;
	logic [10:0]   nump;
	logic [10:0]   six_c;
	logic [NB-1:0] hnum_s2, snum_s2;
	logic [10:0]   hden_s2;
	logic [7:0]    sden_s2;
	logic          czero_s2, mxzero_s2;

	assign f2  = 10'(fold_s1[7:0]) + 10'(fold_s1[9:8]);
	assign res = (f2 >= 10'd255) ? 8'(f2 - 10'd255) : f2[7:0];
	// mod 6 as twice (res/2 mod 3) plus the low bit; base-4 digits sum mod 3
	assign rh  = res[7:1];
	assign s3a = 4'(rh[1:0]) + 4'(rh[3:2]) + 4'(rh[5:4]) + 4'(rh[6]);
	assign s3b = 3'(s3a[1:0]) + 3'(s3a[3:2]);
	assign m3  = (s3b >= 3'd3) ? 2'(s3b - 3'd3) : s3b[1:0];
	assign c1  = mx_s1 - mn_s1;
	assign six_c = 11'(c1) * 11'd6;
	always_comb begin
		if (mx_s1 == r_s1) begin
			num = $signed({4'b0, g_s1}) - $signed({4'b0, b_s1});
		end else if (mx_s1 == g_s1) begin
			num = $signed({3'b0, c1, 1'b0}) + $signed({4'b0, b_s1}) - $signed({4'b0, r_s1});
		end else begin
			num = $signed({2'b0, c1, 2'b0}) + $signed({4'b0, r_s1}) - $signed({4'b0, g_s1});
		end
		nump = (num < 0) ? 11'(num + $signed({1'b0, six_c})) : 11'(num);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hnum_s2   <= NB'(nump) << F;
			snum_s2   <= NB'(c1) << F;
			hden_s2   <= (c1 == 0) ? 11'd1 : six_c;
			sden_s2   <= (mx_s1 == 0) ? 8'd1 : mx_s1;
			czero_s2  <= (c1 == 0);
			mxzero_s2 <= (mx_s1 == 0);
			jj_s2     <= {m3, res[0]};
		end
	end

	logic [NB-1:0] hq, sq;
	logic [4:0]    tg_h;
	logic [4:0]    tg_s;

	hrcg_divider #(.NUM_BITS(NB), .DEN_BITS(11), .TAG_BITS(5)) u_hdiv (
		.clk(clk), .en(adv), .num(hnum_s2), .den(hden_s2),
		.tag_in({czero_s2, mxzero_s2, jj_s2}), .quo(hq), .tag_out(tg_h));
	hrcg_divider #(.NUM_BITS(NB), .DEN_BITS(8), .TAG_BITS(5)) u_sdiv (
		.clk(clk), .en(adv), .num(snum_s2), .den(sden_s2),
		.tag_in(5'd0), .quo(sq), .tag_out(tg_s));

	// stage a: hue shift, saturation floor
	logic [F-1:0] hue, shift, h_s3;
	logic [F:0]   sat, sat_s3;
	assign hue   = tg_h[4] ? '0 : hq[F-1:0];
	assign shift = F'({3'((tg_h[2:0] * 3'd5)), {(F-3){1'b0}}});
	always_comb begin
		sat = tg_h[3] ? '0 : sq[F:0];
		if (sat < (F+1)'(1) << (F-1)) sat = (F+1)'(1) << (F-1);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			h_s3   <= hue + shift;
			sat_s3 <= sat;
		end
	end

	// stage b: sextant and ramp
	logic [F+2:0] hp;
	logic [F:0]   t, d;
	logic [2:0]   sx_s4;
	logic [F:0]   w_s4, sat_s4;
	assign hp = (F+3)'(h_s3) * (F+3)'(6);
	assign t  = hp[F:0];
	assign d  = t[F] ? (t - ((F+1)'(1) << F)) : (((F+1)'(1) << F) - t);
	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s4  <= hp[F+2:F];
			w_s4   <= ((F+1)'(1) << F) - d;
			sat_s4 <= sat_s3;
		end
	end

	// stage c: x
	logic [2*F+1:0] xp;
	logic [F:0]     x_s5, sat_s5;
	logic [2:0]     sx_s5;
	assign xp = (2*F+2)'(sat_s4) * (2*F+2)'(w_s4);
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s5   <= xp[2*F:F];
			sat_s5 <= sat_s4;
			sx_s5  <= sx_s4;
		end
	end

	// stage d: channel select, scale to bytes
	logic [F:0]   cr, cg, cb, m;
	logic [F+8:0] pr, pg, pb;
	rgb_t         res_q;
	assign m = ((F+1)'(1) << F) - sat_s5;
	always_comb begin
		case (sx_s5)
			3'd0: begin cr = sat_s5; cg = x_s5;   cb = '0;     end
			3'd1: begin cr = x_s5;   cg = sat_s5; cb = '0;     end
			3'd2: begin cr = '0;     cg = sat_s5; cb = x_s5;   end
			3'd3: begin cr = '0;     cg = x_s5;   cb = sat_s5; end
			3'd4: begin cr = x_s5;   cg = '0;     cb = sat_s5; end
			default: begin cr = sat_s5; cg = '0;  cb = x_s5;   end
		endcase
		pr = ((F+9)'(cr + m) << 8) - (F+9)'(cr + m);
		pg = ((F+9)'(cg + m) << 8) - (F+9)'(cg + m);
		pb = ((F+9)'(cb + m) << 8) - (F+9)'(cb + m);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.red_out   <= pr[F+7:F];
			res_q.green_out <= pg[F+7:F];
			res_q.blue_out  <= pb[F+7:F];
		end
	end

	assign out_ch.valid     = vld_s[LAT+5];
	assign out_ch.red_out   = res_q.red_out;
	assign out_ch.green_out = res_q.green_out;
	assign out_ch.blue_out  = res_q.blue_out;

	logic unused_tag;
	assign unused_tag = ^tg_s;

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(res_q))
	`ASSERT_IMPLIES(a_rdy, clk, arst_n, !out_ch.valid, in_ch.ready)
	`ASSERT_NEXT(a_shift, clk, arst_n, adv, vld_s[1] == $past(vld_s[0]))
endmodule
